// ----- rtl/rsdm_pkg.sv -----
// shared types and constants for the star/dot pattern matcher
`default_nettype none

package rsdm_pkg;

   // action codes of an input transfer
   localparam logic [1:0] ACT_CLEAR  = 2'd0;
   localparam logic [1:0] ACT_APPEND = 2'd1;
   localparam logic [1:0] ACT_TEXT   = 2'd2;
   localparam logic [1:0] ACT_END    = 2'd3;

   // special pattern bytes
   localparam logic [7:0] STAR_BYTE = 8'h2A;
   localparam logic [7:0] DOT_BYTE  = 8'h2E;

   // per-cell control from the sequencer
   typedef struct packed {
      logic enable;      // cell holds a stored element
      logic load_char;   // store a new element here
      logic set_repeat;  // mark this element as starred
      logic restart;     // return position set to start
      logic step;        // consume one text byte
      logic is_start;    // this cell is position zero
   } cell_ctrl_type;

endpackage

`default_nettype wire

// ----- rtl/rsdm_cell.sv -----
// one pattern element with its active-position bit
`default_nettype none

module rsdm_cell
   import rsdm_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire cell_ctrl_type ctrl,
   input  wire logic [7:0]    data_byte,
   input  wire logic          carry_in,   // closure ripple from previous cell
   input  wire logic          adv_in,     // advance from previous cell
   output logic               carry_out,
   output logic               adv_out,
   output logic               cur_out     // closed position bit
);

   logic [7:0] char_ff;
   logic       rep_ff;
   logic       act_ff;
   logic       act_in;
   logic       hit;

   // closure and byte compare
   assign cur_out   = act_ff | carry_in;
   assign hit       = ctrl.enable && cur_out &&
                      ((char_ff == DOT_BYTE) || (char_ff == data_byte));
   assign carry_out = ctrl.enable && cur_out && rep_ff;
   assign adv_out   = hit && !rep_ff;

   // next position bit
   always_comb begin
      priority if (ctrl.restart) begin
         act_in = ctrl.is_start;
      end else if (ctrl.step) begin
         act_in = (hit && rep_ff) || adv_in;
      end else begin
         act_in = act_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         act_ff <= ctrl.is_start;
      end else begin
         act_ff <= act_in;
      end
   end

   // element storage
   always_ff @(posedge clock) begin
      if (ctrl.load_char) begin
         char_ff <= data_byte;
         rep_ff  <= 1'b0;
      end else if (ctrl.set_repeat) begin
         rep_ff  <= 1'b1;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/regex_star_dot_matcher_core.sv -----
// top level of the star/dot pattern matcher
//
// Input channel (req_): action and data_byte. Clear empties the pattern,
// append adds one pattern byte ('*' marks the previous element as
// repeatable), text feeds one text byte, end of text closes the text.
// Result channel (rsp_): one transfer for each end of text, carrying
// matched and pattern_overflow.
// Every action is taken at once, one transfer per clock while req_ready
// is high. The pattern lives in a row of MAX_ELEMENTS cells,
// each holding one element and one position bit; the closure over starred
// elements ripples through the row within the cycle, which sets the clock.
// The result is registered and shows in the cycle after the end transfer.
// Reset empties the pattern, clears the overflow flag and puts the text
// state at the start position. While a result waits and rsp_ready is low,
// req_ready is low; it rises in the cycle the result is taken.
`default_nettype none

module regex_star_dot_matcher_core
   import rsdm_pkg::*;
#(
   parameter int MAX_ELEMENTS = 32
)
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [1:0] req_action,
   input  wire logic [7:0] req_data_byte,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic            rsp_matched,
   output logic            rsp_pattern_overflow
);

   localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);

   logic [CNT_W-1:0]      count_ff, count_in;
   logic                  overflow_ff, overflow_in;
   logic                  act_last_ff, act_last_in;
   logic                  rsp_valid_ff;
   logic                  rsp_matched_ff;
   logic                  rsp_overflow_ff;

   logic                  accept;
   logic                  is_clear, is_append, is_text, is_end;
   logic                  restart, append_elem, star_mark;
   logic [MAX_ELEMENTS-1:0] carry, adv;
   logic [MAX_ELEMENTS:0]   cur_vec;
   logic [MAX_ELEMENTS:0]   beyond;
   logic                  fin;

   // handshake
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   // action decode
   assign is_clear  = accept && (req_action == ACT_CLEAR);
   assign is_append = accept && (req_action == ACT_APPEND);
   assign is_text   = accept && (req_action == ACT_TEXT);
   assign is_end    = accept && (req_action == ACT_END);
   assign restart   = is_clear || is_append || is_end;

   assign append_elem = is_append && !overflow_ff && (req_data_byte != STAR_BYTE) &&
                        (count_ff != CNT_W'(MAX_ELEMENTS));
   assign star_mark   = is_append && !overflow_ff && (req_data_byte == STAR_BYTE);

   // row of element cells
   for (genvar i = 0; i < MAX_ELEMENTS; i++) begin : g_cell
      cell_ctrl_type ctrl;
      logic          carry_in, adv_in;

      assign ctrl.enable     = count_ff > CNT_W'(i);
      assign ctrl.load_char  = append_elem && (count_ff == CNT_W'(i));
      assign ctrl.set_repeat = star_mark && (count_ff == CNT_W'(i + 1));
      assign ctrl.restart    = restart;
      assign ctrl.step       = is_text;
      assign ctrl.is_start   = (i == 0);

      if (i == 0) begin : g_first
         assign carry_in = 1'b0;
         assign adv_in   = 1'b0;
      end else begin : g_rest
         assign carry_in = carry[i-1];
         assign adv_in   = adv[i-1];
      end

      rsdm_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctrl      (ctrl),
         .data_byte (req_data_byte),
         .carry_in  (carry_in),
         .adv_in    (adv_in),
         .carry_out (carry[i]),
         .adv_out   (adv[i]),
         .cur_out   (cur_vec[i])
      );

      assign beyond[i] = cur_vec[i] && (CNT_W'(i) > count_ff);
   end

   // final position past the last cell
   assign cur_vec[MAX_ELEMENTS] = act_last_ff | carry[MAX_ELEMENTS-1];
   assign beyond[MAX_ELEMENTS]  = 1'b0;
   assign fin = cur_vec[count_ff];

   always_comb begin
      priority if (restart) begin
         act_last_in = 1'b0;
      end else if (is_text) begin
         act_last_in = adv[MAX_ELEMENTS-1];
      end else begin
         act_last_in = act_last_ff;
      end
   end

   // element count and overflow flag
   always_comb begin
      count_in    = count_ff;
      overflow_in = overflow_ff;
      if (is_clear) begin
         count_in    = '0;
         overflow_in = 1'b0;
      end else if (append_elem) begin
         count_in    = count_ff + CNT_W'(1);
      end else if (is_append && !overflow_ff && (req_data_byte != STAR_BYTE)) begin
         overflow_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         overflow_ff <= 1'b0;
         act_last_ff <= 1'b0;
      end else begin
         count_ff    <= count_in;
         overflow_ff <= overflow_in;
         act_last_ff <= act_last_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (is_end) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (is_end) begin
         rsp_matched_ff  <= fin;
         rsp_overflow_ff <= overflow_ff;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_matched          = rsp_matched_ff;
   assign rsp_pattern_overflow = rsp_overflow_ff;

   // checks
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_ELEMENTS))
      else $error("element count above capacity");

   a_overflow_full: assert property (@(posedge clock) disable iff (reset)
      overflow_ff |-> (count_ff == CNT_W'(MAX_ELEMENTS)))
      else $error("overflow flag set with room left");

   a_positions_bounded: assert property (@(posedge clock) disable iff (reset)
      beyond == '0)
      else $error("active position beyond pattern end");

   a_end_result: assert property (@(posedge clock) disable iff (reset)
      is_end |=> rsp_valid_ff)
      else $error("end of text transfer gave no result");

endmodule

`default_nettype wire
